// ===== rtl/ptw_pkg.sv =====
// Shared types and constants for the page table walker.
// Holds field layout, fault and mode codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int PTW_TABLE_WORDS = 4096;

  localparam int IN_IDX_LSB  = 0;
  localparam int IN_VAL_LSB  = 12;
  localparam int IN_VA_LSB   = 76;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 44;

  typedef logic [2:0] fault_t;

  localparam fault_t FAULT_OK      = 3'd0;
  localparam fault_t FAULT_POISON  = 3'd1;
  localparam fault_t FAULT_INVALID = 3'd2;
  localparam fault_t FAULT_NO_LEAF = 3'd3;
  localparam fault_t FAULT_NO_READ = 3'd4;

  localparam logic [1:0] MODE_SV32 = 2'd1;
  localparam logic [1:0] MODE_SV39 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd2;

  localparam logic [31:0] POISON_WORD = 32'hbaadf00d;

  typedef struct packed {
    logic   clr_write;
    logic   mem_write;
    logic   load_item;
    logic   issue_read;
    logic   descend;
    logic   out_load;
    logic   out_bare;
    fault_t out_fault;
  } ptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_write;
    logic walk_mode;
    logic poison;
    logic invalid;
    logic pointer;
    logic last_level;
    logic readable;
    logic out_free;
  } ptw_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ptw_ctrl.sv =====
// Walk sequencer: clearing pass, item accept, per-level read/evaluate, result load.
// Depends on ptw_pkg.
`default_nettype none

module ptw_ctrl
  import ptw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire ptw_sts_t sts,
  output ptw_cmd_t      cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_BARE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  fault_t     fault_sel;

  always_comb begin
    if (sts.poison) begin
      fault_sel = FAULT_POISON;
    end else if (sts.invalid) begin
      fault_sel = FAULT_INVALID;
    end else if (sts.pointer) begin
      fault_sel = FAULT_NO_LEAF;
    end else if (!sts.readable) begin
      fault_sel = FAULT_NO_READ;
    end else begin
      fault_sel = FAULT_OK;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (sts.in_write) begin
            cmd.mem_write = 1'b1;
          end else begin
            cmd.load_item = 1'b1;
            state_nxt     = sts.walk_mode ? ST_ADDR : ST_BARE;
          end
        end
      end
      ST_ADDR: begin
        cmd.issue_read = 1'b1;
        state_nxt      = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts.poison && !sts.invalid && sts.pointer && !sts.last_level) begin
          cmd.descend = 1'b1;
          state_nxt   = ST_ADDR;
        end else if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_fault = fault_sel;
          state_nxt     = ST_IDLE;
        end
      end
      ST_BARE: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_bare  = 1'b1;
          cmd.out_fault = FAULT_OK;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |-> $past(state_r) == ST_ADDR || $past(state_r) == ST_EVAL)
    else $error("evaluate state entered without a table read");

endmodule

`default_nettype wire

// ===== rtl/ptw_datapath.sv =====
// Walker datapath: config registers, table store, entry address and range check,
// entry decode, physical address assembly and the output register.
// Depends on ptw_pkg.
`default_nettype none

module ptw_datapath
  import ptw_pkg::*;
#(
  parameter int TABLE_WORDS = PTW_TABLE_WORDS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_tuser,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire ptw_cmd_t               cmd,
  output ptw_sts_t                    sts
);

  localparam int AW          = $clog2(TABLE_WORDS);
  localparam int TABLE_BYTES = TABLE_WORDS * 8;

  logic [1:0]        mode_r;
  logic [43:0]       root_ppn_r;
  logic [43:0]       region_ppn_r;
  logic [38:0]       va_r;
  logic              sv32_r;
  logic [1:0]        level_r;
  logic [43:0]       base_r;
  logic [AW-1:0]     clr_addr_r;
  logic [63:0]       mem_r [TABLE_WORDS];
  logic [63:0]       rd_data_r;
  logic              in_range_r;
  logic              half_r;
  logic              out_valid_r;
  logic [55:0]       out_pa_r;
  fault_t            out_fault_r;

  logic [11:0]       entry_index;
  logic [63:0]       entry_value;
  logic [38:0]       virt_addr;
  logic              idx_ok;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [63:0]       mem_wd;
  logic [11:0]       off12;
  logic [44:0]       diff;
  logic [55:0]       off;
  logic              in_range;
  logic [63:0]       word;
  logic [63:0]       pte;
  logic [43:0]       ppn;
  logic [55:0]       va_keep;
  logic [55:0]       leaf_pa;

  assign entry_index = in_tdata[IN_IDX_LSB +: 12];
  assign entry_value = in_tdata[IN_VAL_LSB +: 64];
  assign virt_addr   = in_tdata[IN_VA_LSB +: 39];
  assign idx_ok      = {20'd0, entry_index} < 32'(TABLE_WORDS);

  assign mem_we = cmd.clr_write || (cmd.mem_write && idx_ok);
  assign mem_wa = cmd.clr_write ? clr_addr_r : AW'(entry_index);
  assign mem_wd = cmd.clr_write ? 64'd0 : entry_value;

  always_comb begin
    case ({sv32_r, level_r})
      3'b010:  off12 = {va_r[38:30], 3'b000};
      3'b001:  off12 = {va_r[29:21], 3'b000};
      3'b000:  off12 = {va_r[20:12], 3'b000};
      3'b101:  off12 = {va_r[31:22], 2'b00};
      3'b100:  off12 = {va_r[21:12], 2'b00};
      default: off12 = {va_r[20:12], 3'b000};
    endcase
  end

  assign diff     = {1'b0, base_r} - {1'b0, region_ppn_r};
  assign off      = {diff[43:0], off12};
  assign in_range = !diff[44] && (off < 56'(TABLE_BYTES));

  assign word = in_range_r ? rd_data_r : 64'd0;
  assign pte  = sv32_r ? {32'd0, (half_r ? word[63:32] : word[31:0])} : word;
  assign ppn  = pte[53:10];

  always_comb begin
    case ({sv32_r, level_r})
      3'b001:  va_keep = 56'h1FFFFF;
      3'b010:  va_keep = 56'h3FFFFFFF;
      3'b101:  va_keep = 56'h3FFFFF;
      default: va_keep = 56'hFFF;
    endcase
  end

  assign leaf_pa = ({ppn, 12'd0} & ~va_keep) | ({17'd0, va_r} & va_keep);

  assign sts.clr_last   = clr_addr_r == AW'(TABLE_WORDS - 1);
  assign sts.in_write   = !in_tuser;
  assign sts.walk_mode  = (mode_r == MODE_SV32) || (mode_r == MODE_SV39);
  assign sts.poison     = pte[31:0] == POISON_WORD;
  assign sts.invalid    = !pte[0] || (!pte[1] && pte[2]);
  assign sts.pointer    = !pte[1] && !pte[2] && !pte[3];
  assign sts.last_level = level_r == 2'd0;
  assign sts.readable   = pte[1];
  assign sts.out_free   = !out_valid_r || out_tready;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_fault_r, out_pa_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 2'd0;
      root_ppn_r   <= 44'd0;
      region_ppn_r <= 44'd0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MODE:   mode_r       <= cfg_data[1:0];
          CFG_ROOT:   root_ppn_r   <= cfg_data;
          CFG_REGION: region_ppn_r <= cfg_data;
          default:    ;
        endcase
      end
      if (cmd.clr_write) clr_addr_r <= clr_addr_r + AW'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (cmd.issue_read) rd_data_r <= mem_r[off[AW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      va_r    <= virt_addr;
      sv32_r  <= mode_r == MODE_SV32;
      level_r <= (mode_r == MODE_SV32) ? 2'd1 : 2'd2;
      base_r  <= root_ppn_r;
    end else if (cmd.descend) begin
      level_r <= level_r - 2'd1;
      base_r  <= ppn;
    end
    if (cmd.issue_read) begin
      in_range_r <= in_range;
      half_r     <= off[2];
    end
    if (cmd.out_load) begin
      out_fault_r <= cmd.out_fault;
      if (cmd.out_bare) begin
        out_pa_r <= {17'd0, va_r};
      end else if (cmd.out_fault == FAULT_OK) begin
        out_pa_r <= leaf_pa;
      end else begin
        out_pa_r <= 56'd0;
      end
    end
  end

  a_read_write_apart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_read |-> !mem_we)
    else $error("table read and write in the same cycle");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_tready)
    else $error("result loaded over a waiting result");

  a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r != FAULT_OK |-> out_pa_r == 56'd0)
    else $error("faulted result carries a nonzero address");

endmodule

`default_nettype wire

// ===== rtl/riscv_page_table_walker_unit.sv =====
// Top level of the Sv32/Sv39 page table walker.
// Instantiates ptw_ctrl and ptw_datapath; depends on ptw_pkg.
//
//   channel | direction | ports                               | contents
//   in_     | input     | tvalid tready tdata[119:0] tuser    | store write or translate
//   out_    | output    | tvalid tready tdata[63:0]           | address and fault code
//   cfg_    | input     | valid ready index[1:0] data[43:0]   | register write
//
// After reset a clearing pass zeroes the table store, with in_tready low throughout.
// A write item is done in the accept state; a bare-mode translate accepts, then loads the result;
// a walk accepts, then per level does one registered store read and one decode step.
// One item is in the walk at a time; the output register lets a new item be accepted
// while a result waits, and the walk holds in its last state while a result waits and out_tready is low.
`default_nettype none

module riscv_page_table_walker_unit
  import ptw_pkg::*;
#(
  parameter int TABLE_WORDS = PTW_TABLE_WORDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // entry_index[11:0], entry_value[75:12], virt_addr[114:76], zero pad
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // action
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // phys_addr[55:0], fault_code[58:56], zero pad
  output logic [OUT_TDATA_W-1:0]     out_tdata
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptw_datapath #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== tb/riscv_page_table_walker_unit_tb.sv =====
// Self-checking testbench for riscv_page_table_walker_unit: table writes, bare translates and Sv32/Sv39 walks.
// A scoreboard class mirrors the table store and registers and predicts each translation.
// Depends on ptw_pkg and the RTL top level only.
`timescale 1ns / 100ps

module riscv_page_table_walker_unit_tb
  import ptw_pkg::*;
();

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          ITEM_TARGET  = 1450;
  localparam int          FAULT_LSB    = 56;
  localparam bit          ACT_WRITE    = 1'b0;
  localparam bit          ACT_XLATE    = 1'b1;
  localparam bit [1:0]    MODE_BARE    = 2'd0;
  localparam bit [1:0]    MODE_UNUSED  = 2'd3;
  localparam bit [43:0]   PPN_MAX      = 44'hFFF_FFFF_FFFF;

  typedef enum int {
    PTE_POINTER, PTE_LEAF, PTE_EXEC_ONLY, PTE_INVALID, PTE_WRITE_ONLY, PTE_POISON
  } pte_kind_t;

  typedef struct packed {
    bit [55:0] pa;
    fault_t    fault;
  } xlate_t;

  class walk_scoreboard;
    bit [63:0] store [PTW_TABLE_WORDS];
    bit [1:0]  mode;
    bit [43:0] root_ppn;
    bit [43:0] region_ppn;
    xlate_t    expected_xlate [$];
    int        mismatches;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:   mode = val[1:0];
        CFG_ROOT:   root_ppn = val;
        CFG_REGION: region_ppn = val;
        default: ;
      endcase
    endfunction

    function bit [63:0] fetch(bit [63:0] addr, bit narrow);
      bit [63:0] base;
      bit [63:0] off;
      bit [63:0] word;
      base = {8'b0, region_ppn, 12'b0};
      if (addr < base) return 64'd0;
      off = addr - base;
      if (off >= PTW_TABLE_WORDS * 8) return 64'd0;
      word = store[off >> 3];
      if (narrow) word = off[2] ? {32'b0, word[63:32]} : {32'b0, word[31:0]};
      return word;
    endfunction

    function xlate_t translate(bit [38:0] va);
      xlate_t    r;
      bit        narrow;
      int        bits;
      int        lvl;
      bit [63:0] va64;
      bit [63:0] base;
      bit [63:0] vpn;
      bit [63:0] pte;
      bit [63:0] va_keep;
      r.pa = '0;
      r.fault = FAULT_OK;
      va64 = va;
      if (mode != MODE_SV32 && mode != MODE_SV39) begin
        r.pa = va64[55:0];
        return r;
      end
      narrow = (mode == MODE_SV32);
      bits = narrow ? 10 : 9;
      lvl = narrow ? 1 : 2;
      base = root_ppn;
      forever begin
        vpn = (va64 >> (12 + lvl * bits)) & ((64'd1 << bits) - 1);
        pte = fetch((base << 12) + (vpn << (narrow ? 2 : 3)), narrow);
        if (pte[31:0] == POISON_WORD) begin
          r.fault = FAULT_POISON;
          return r;
        end
        if (!pte[0] || (!pte[1] && pte[2])) begin
          r.fault = FAULT_INVALID;
          return r;
        end
        if (pte[3:1] == 3'b000) begin
          if (lvl == 0) begin
            r.fault = FAULT_NO_LEAF;
            return r;
          end
          lvl--;
          base = {20'b0, pte[53:10]};
          continue;
        end
        if (!pte[1]) begin
          r.fault = FAULT_NO_READ;
          return r;
        end
        base = {20'b0, pte[53:10]};
        break;
      end
      va_keep = (64'd1 << (12 + lvl * bits)) - 1;
      pte = ((base << 12) & ~va_keep) | (va64 & va_keep);
      r.pa = pte[55:0];
      return r;
    endfunction

    function void note_item(bit act, bit [11:0] idx, bit [63:0] val, bit [38:0] va);
      if (act == ACT_WRITE) begin
        if (idx < PTW_TABLE_WORDS) store[idx] = val;
      end else begin
        expected_xlate.push_back(translate(va));
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      xlate_t want;
      if (expected_xlate.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no translation pending: %h", tdata);
        return;
      end
      want = expected_xlate.pop_front();
      if (tdata[55:0] !== want.pa || tdata[FAULT_LSB +: 3] !== want.fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: phys_addr exp %h got %h, fault_code exp %0d got %0d",
                   want.pa, tdata[55:0], want.fault, tdata[FAULT_LSB +: 3]);
      end
    endfunction

    function int pending();
      return expected_xlate.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  walk_scoreboard sb;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int rx_style = 0;
  int rx_left = 0;
  int stall_left = 0;

  riscv_page_table_walker_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** riscv_page_table_walker_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 10);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [38:0] sv39_va(bit [8:0] v2, bit [8:0] v1, bit [8:0] v0);
    return {v2, v1, v0, 12'($urandom)};
  endfunction

  function automatic bit [63:0] make_pte(pte_kind_t kind, bit [43:0] ppn);
    bit [63:0] r;
    r = rand64();
    r[53:10] = ppn;
    case (kind)
      PTE_POINTER:    r[3:0] = 4'b0001;
      PTE_LEAF:       r[1:0] = 2'b11;
      PTE_EXEC_ONLY:  r[3:0] = 4'b1001;
      PTE_INVALID:    r[0] = 1'b0;
      PTE_WRITE_ONLY: r[2:0] = 3'b101;
      default:        r[31:0] = POISON_WORD;
    endcase
    return r;
  endfunction

  function automatic pte_kind_t pick_terminal();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return PTE_LEAF;
    if (r < 79) return PTE_EXEC_ONLY;
    if (r < 85) return PTE_INVALID;
    if (r < 90) return PTE_WRITE_ONLY;
    if (r < 95) return PTE_POISON;
    return PTE_POINTER;
  endfunction

  task automatic send_item(bit act, bit [11:0] idx, bit [63:0] val, bit [38:0] va);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_IDX_LSB +: 12] = idx;
    word[IN_VAL_LSB +: 64] = val;
    word[IN_VA_LSB +: 39] = va;
    in_tdata <= word;
    in_tuser <= act;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(act, idx, val, va);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(0, 20);
    end
  endtask

  task automatic write_entry(bit [11:0] idx, bit [63:0] val);
    send_item(ACT_WRITE, idx, val, 39'(rand64()));
  endtask

  task automatic xlate(bit [38:0] va);
    send_item(ACT_XLATE, 12'($urandom), rand64(), va);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(bit [1:0] mode, bit [43:0] root, bit [43:0] region);
    cfg_put(CFG_MODE, {42'b0, mode});
    cfg_put(CFG_ROOT, root);
    cfg_put(CFG_REGION, region);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one walk path for va into the store, then translate addresses that share its leaf page.
  task automatic walk_path(bit [38:0] va);
    bit        narrow;
    int        bits;
    int        leaf_lvl;
    int        lv;
    int        pg;
    int        nxt;
    int        w;
    bit [43:0] diff;
    bit [63:0] vpn;
    bit [63:0] pte;
    bit [63:0] old;
    bit [63:0] low_mask;
    bit [38:0] va2;
    narrow = (sb.mode == MODE_SV32);
    bits = narrow ? 10 : 9;
    leaf_lvl = $urandom_range(0, narrow ? 1 : 2);
    diff = sb.root_ppn - sb.region_ppn;
    pg = (diff < 8) ? int'(diff) : $urandom_range(0, 7);
    for (lv = narrow ? 1 : 2; lv >= leaf_lvl; lv--) begin
      vpn = ({25'b0, va} >> (12 + lv * bits)) & ((64'd1 << bits) - 1);
      w = pg * 512 + int'(narrow ? vpn >> 1 : vpn);
      if (lv > leaf_lvl) begin
        nxt = $urandom_range(0, 7);
        pte = make_pte(PTE_POINTER, sb.region_ppn + 44'(nxt));
        pg = nxt;
      end else begin
        pte = make_pte(pick_terminal(), 44'(rand64()));
      end
      if (narrow) begin
        old = sb.store[w];
        pte = vpn[0] ? {pte[31:0], old[31:0]} : {old[63:32], pte[31:0]};
      end
      write_entry(12'(w), pte);
    end
    low_mask = (64'd1 << (12 + leaf_lvl * bits)) - 1;
    repeat ($urandom_range(1, 3)) begin
      va2 = 39'(({25'b0, va} & ~low_mask) | (rand64() & low_mask));
      if (narrow) va2[38:32] = 7'($urandom);
      xlate(va2);
    end
  endtask

  initial begin
    bit [43:0] reg_root;
    bit [43:0] reg_region;
    bit [1:0]  reg_mode;
    int        phase;
    int        start;
    int        len;
    int        r;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    xlate('0);
    xlate('1);
    wait_idle();
    set_config(MODE_UNUSED, 44'd0, 44'd0);
    xlate(39'(rand64()));
    wait_idle();

    reg_region = 44'h00A_BCDE_F012;
    set_config(MODE_SV39, reg_region, reg_region);
    write_entry(12'd0, '1);
    xlate(sv39_va(9'd0, 9'($urandom), 9'($urandom)));
    write_entry(12'd1, make_pte(PTE_POINTER, reg_region + 44'd1));
    write_entry(12'd512, make_pte(PTE_LEAF, 44'(rand64())));
    xlate(sv39_va(9'd1, 9'd0, 9'($urandom)));
    write_entry(12'd513, make_pte(PTE_POINTER, reg_region + 44'd2));
    write_entry(12'd1029, make_pte(PTE_LEAF, 44'(rand64())));
    xlate(sv39_va(9'd1, 9'd1, 9'd5));
    write_entry(12'd1030, make_pte(PTE_POINTER, 44'(rand64())));
    xlate(sv39_va(9'd1, 9'd1, 9'd6));
    write_entry(12'd1031, make_pte(PTE_EXEC_ONLY, 44'(rand64())));
    xlate(sv39_va(9'd1, 9'd1, 9'd7));
    write_entry(12'd2, make_pte(PTE_WRITE_ONLY, 44'(rand64())));
    xlate(sv39_va(9'd2, 9'($urandom), 9'($urandom)));
    write_entry(12'd3, make_pte(PTE_POISON, 44'(rand64())));
    xlate(sv39_va(9'd3, 9'($urandom), 9'($urandom)));
    write_entry(12'd4095, '0);
    xlate(sv39_va(9'd4, 9'($urandom), 9'($urandom)));
    wait_idle();

    set_config(MODE_SV32, 44'h12345, 44'h12345);
    xlate({7'($urandom), 10'd1, 22'($urandom)});
    xlate({7'($urandom), 10'd6, 22'($urandom)});

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      r = $urandom_range(0, 99);
      reg_mode = (r < 8) ? MODE_BARE : (r < 12) ? MODE_UNUSED :
                 (r < 55) ? MODE_SV39 : MODE_SV32;
      if (reg_mode == MODE_SV32) reg_region = 44'($urandom_range(0, (1 << 22) - 9));
      else reg_region = 44'(rand64());
      if (reg_region > PPN_MAX - 44'd8) reg_region = reg_region - 44'd8;
      if ($urandom_range(0, 9) == 0) reg_region = 44'd0;
      r = $urandom_range(0, 9);
      reg_root = (r == 0) ? PPN_MAX : (r == 1) ? 44'(rand64()) :
                 reg_region + 44'($urandom_range(0, 7));
      if (phase == 0) begin
        reg_mode = MODE_SV32;
        reg_region = '0;
        reg_root = '0;
      end else if (phase == 1) begin
        reg_mode = MODE_SV39;
        reg_region = PPN_MAX;
        reg_root = PPN_MAX;
      end
      set_config(reg_mode, reg_root, reg_region);
      phase++;
      start = items_sent;
      len = $urandom_range(80, 160);
      while (items_sent - start < len && items_sent < ITEM_TARGET) begin
        r = $urandom_range(0, 99);
        if ((reg_mode == MODE_SV32 || reg_mode == MODE_SV39) && r < 70)
          walk_path(39'(rand64()));
        else if (r < 85)
          write_entry(12'($urandom), $urandom_range(0, 1) ? rand64() :
                      make_pte(pte_kind_t'($urandom_range(0, 5)),
                               reg_region + 44'($urandom_range(0, 7))));
        else
          xlate(39'(rand64()));
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** riscv_page_table_walker_unit: PASSED **");
    else
      $display("** riscv_page_table_walker_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptw_pkg.sv
rtl/ptw_ctrl.sv
rtl/ptw_datapath.sv
rtl/riscv_page_table_walker_unit.sv
tb/riscv_page_table_walker_unit_tb.sv
